@@ sv/uniform_table_interpolator_macros.svh @@
// Assertion macros shared by the interpolator RTL.
`ifndef UNIFORM_TABLE_INTERPOLATOR_MACROS_SVH
`define UNIFORM_TABLE_INTERPOLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/uti_pkg.sv @@
// Shared types, constants and helper functions of the uniform table interpolator.
package uti_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_EMPTY  = 2'd0,
      STATUS_INTERP = 2'd1,
      STATUS_HELD   = 2'd2,
      STATUS_ZERO   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TIME   = 3'd0,
      CSR_STEP_RECIP   = 3'd1,
      CSR_SCALE_FACTOR = 3'd2,
      CSR_HOLD_LAST    = 3'd3,
      CSR_PREPEND_ZERO = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_IDX,
      ST_RDA,
      ST_RDB,
      ST_LERP,
      ST_SCALE,
      ST_PEAK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   // Floor of a signed Q34.32 product to Q16.16, saturated to 32 bits.
   function automatic logic [DATA_W-1:0] sat_q16(input logic [PROD_W-1:0] p);
      logic [PROD_W-48:0] hi;
      hi = p[PROD_W-1:47];
      if ((&hi) || !(|hi)) begin
         return p[47:16];
      end else if (p[PROD_W-1]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

endpackage

@@ sv/uti_mul.sv @@
// Shared signed 33x33 multiplier with a registered product.
module uti_mul (
   input  logic                              clock,
   input  logic signed [uti_pkg::MUL_W-1:0]  mul_a,
   input  logic signed [uti_pkg::MUL_W-1:0]  mul_b,
   output logic signed [uti_pkg::PROD_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

@@ sv/uti_store.sv @@
// Sample memory with one write port and one registered read port.
module uti_store (
   input  logic                          clock,
   input  uti_pkg::store_wr_type         wr,
   input  logic [uti_pkg::ADDR_W-1:0]    rd_addr,
   output logic [uti_pkg::DATA_W-1:0]    rd_data_ff
);

   logic [uti_pkg::DATA_W-1:0] mem [uti_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ sv/uniform_table_interpolator.sv @@
// Top level of the uniform table interpolator: sequencer, registers and result port.
//
// Requests enter on req_op/req_sample_value/req_query_time and are taken at a clock
// edge with start high and busy low. Clear and append finish in the accepting cycle
// and keep busy low, so they may follow one another every cycle. A query raises busy
// and walks a sequencer around one shared 33x33 multiplier and the one read port of
// the sample memory: position, two sample reads, interpolation, scaling, peak scaling.
// An empty store or a time before the start goes straight to scaling; a time past
// the end gives zero after the position step, or holds the last sample after one
// read; otherwise both samples are read and interpolated. busy falls in the strobe
// cycle, so a new query may be accepted then. The result is on the rsp_ ports for
// exactly one cycle, marked by rsp_strobe; the receiver cannot stall it. Registers
// are written on the csr_ channel, which is always ready; it is to be used only while
// the block is idle, which the user must ensure, as the block does not enforce it.
// Synchronous reset empties the store, clears the peak, loads register defaults
// and returns the sequencer to idle; the memory itself is not cleared.
`include "uniform_table_interpolator_macros.svh"

module uniform_table_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [31:0]                      req_sample_value,
   input  logic [31:0]                      req_query_time,
   output logic                             rsp_strobe,
   output logic [31:0]                      rsp_scaled_value,
   output logic [31:0]                      rsp_unscaled_value,
   output logic [31:0]                      rsp_peak_value,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [uti_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_data
);

   localparam logic [uti_pkg::CNT_W-1:0] CNT_DEPTH = uti_pkg::CNT_W'(uti_pkg::DEPTH);

   uti_pkg::state_type  state_ff, state_in;
   uti_pkg::status_type status_ff, status_in;

   logic [31:0] start_time_ff, start_time_in;
   logic [31:0] step_recip_ff, step_recip_in;
   logic [31:0] scale_ff, scale_in;
   logic        hold_ff, hold_in;
   logic        prepend_ff, prepend_in;

   logic [uti_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [31:0]                peak_ff, peak_in;
   logic [31:0]                diff_ff, diff_in;
   logic [15:0]                frac_ff, frac_in;
   logic [uti_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [31:0]                a_ff, a_in;
   logic [31:0]                unscaled_ff, unscaled_in;
   logic [31:0]                scaled_ff, scaled_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [31:0] rsp_scaled_ff, rsp_scaled_in;
   logic [31:0] rsp_unscaled_ff, rsp_unscaled_in;
   logic [31:0] rsp_peak_ff, rsp_peak_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [uti_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [uti_pkg::PROD_W-1:0] mul_p;

   uti_pkg::store_wr_type      store_wr;
   logic [uti_pkg::ADDR_W-1:0] rd_addr;
   logic [31:0]                rd_data;

   logic [31:0]               append_mag;
   logic [31:0]               pos_idx;
   logic                      past_end;
   logic [uti_pkg::CNT_W-1:0] cnt_last;

   uti_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

   uti_store u_store (
      .clock      (clock),
      .wr         (store_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign busy               = (state_ff != uti_pkg::ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_scaled_value   = rsp_scaled_ff;
   assign rsp_unscaled_value = rsp_unscaled_ff;
   assign rsp_peak_value     = rsp_peak_ff;
   assign rsp_status         = rsp_status_ff;

   // Magnitude as unsigned, so the most negative sample gives 2^31.
   assign append_mag = req_sample_value[31] ? (~req_sample_value + 32'd1) : req_sample_value;
   assign pos_idx    = mul_p[63:32];
   assign past_end   = ({1'b0, pos_idx} + 33'd1) >= {{(33 - uti_pkg::CNT_W){1'b0}}, count_ff};
   assign cnt_last   = count_ff - 1'b1;

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      start_time_in   = start_time_ff;
      step_recip_in   = step_recip_ff;
      scale_in        = scale_ff;
      hold_in         = hold_ff;
      prepend_in      = prepend_ff;
      count_in        = count_ff;
      peak_in         = peak_ff;
      diff_in         = diff_ff;
      frac_in         = frac_ff;
      idx_in          = idx_ff;
      a_in            = a_ff;
      unscaled_in     = unscaled_ff;
      scaled_in       = scaled_ff;
      rsp_strobe_in   = 1'b0;
      rsp_scaled_in   = rsp_scaled_ff;
      rsp_unscaled_in = rsp_unscaled_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_status_in   = rsp_status_ff;
      mul_a           = '0;
      mul_b           = '0;
      store_wr        = '0;
      rd_addr         = '0;

      if (csr_valid) begin
         case (csr_index)
            uti_pkg::CSR_START_TIME:   start_time_in = csr_data;
            uti_pkg::CSR_STEP_RECIP:   step_recip_in = csr_data;
            uti_pkg::CSR_SCALE_FACTOR: scale_in      = csr_data;
            uti_pkg::CSR_HOLD_LAST:    hold_in       = csr_data[0];
            uti_pkg::CSR_PREPEND_ZERO: prepend_in    = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         uti_pkg::ST_IDLE: begin
            if (start) begin
               case (uti_pkg::op_type'(req_op))
                  uti_pkg::OP_CLEAR: begin
                     peak_in       = '0;
                     count_in      = prepend_ff ? uti_pkg::CNT_W'(1) : '0;
                     store_wr.en   = prepend_ff;
                     store_wr.addr = '0;
                     store_wr.data = '0;
                  end
                  uti_pkg::OP_APPEND: begin
                     if (count_ff < CNT_DEPTH) begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = count_ff[uti_pkg::ADDR_W-1:0];
                        store_wr.data = req_sample_value;
                        count_in      = count_ff + 1'b1;
                        if (append_mag > peak_ff) begin
                           peak_in = append_mag;
                        end
                     end
                  end
                  uti_pkg::OP_QUERY: begin
                     diff_in     = req_query_time - start_time_ff;
                     unscaled_in = '0;
                     status_in   = uti_pkg::STATUS_EMPTY;
                     if (count_ff == '0 || req_query_time < start_time_ff) begin
                        state_in = uti_pkg::ST_SCALE;
                     end else begin
                        state_in = uti_pkg::ST_POS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         uti_pkg::ST_POS: begin
            mul_a    = {1'b0, diff_ff};
            mul_b    = {1'b0, step_recip_ff};
            state_in = uti_pkg::ST_IDX;
         end
         uti_pkg::ST_IDX: begin
            frac_in = mul_p[31:16];
            if (past_end) begin
               if (hold_ff) begin
                  rd_addr   = cnt_last[uti_pkg::ADDR_W-1:0];
                  status_in = uti_pkg::STATUS_HELD;
                  state_in  = uti_pkg::ST_RDA;
               end else begin
                  status_in = uti_pkg::STATUS_ZERO;
                  state_in  = uti_pkg::ST_SCALE;
               end
            end else begin
               rd_addr   = pos_idx[uti_pkg::ADDR_W-1:0];
               idx_in    = pos_idx[uti_pkg::ADDR_W-1:0];
               status_in = uti_pkg::STATUS_INTERP;
               state_in  = uti_pkg::ST_RDA;
            end
         end
         uti_pkg::ST_RDA: begin
            if (status_ff == uti_pkg::STATUS_HELD) begin
               unscaled_in = rd_data;
               state_in    = uti_pkg::ST_SCALE;
            end else begin
               a_in     = rd_data;
               rd_addr  = idx_ff + 1'b1;
               state_in = uti_pkg::ST_RDB;
            end
         end
         uti_pkg::ST_RDB: begin
            mul_a    = {rd_data[31], rd_data} - {a_ff[31], a_ff};
            mul_b    = {17'b0, frac_ff};
            state_in = uti_pkg::ST_LERP;
         end
         uti_pkg::ST_LERP: begin
            // The interpolated value lies between the two samples, so 32 bits hold it.
            unscaled_in = a_ff + mul_p[47:16];
            state_in    = uti_pkg::ST_SCALE;
         end
         uti_pkg::ST_SCALE: begin
            mul_a    = {unscaled_ff[31], unscaled_ff};
            mul_b    = {scale_ff[31], scale_ff};
            state_in = uti_pkg::ST_PEAK;
         end
         uti_pkg::ST_PEAK: begin
            scaled_in = uti_pkg::sat_q16(mul_p);
            mul_a     = {1'b0, peak_ff};
            mul_b     = {scale_ff[31], scale_ff};
            state_in  = uti_pkg::ST_DONE;
         end
         uti_pkg::ST_DONE: begin
            rsp_scaled_in   = scaled_ff;
            rsp_unscaled_in = unscaled_ff;
            rsp_peak_in     = uti_pkg::sat_q16(mul_p);
            rsp_status_in   = status_ff;
            rsp_strobe_in   = 1'b1;
            state_in        = uti_pkg::ST_IDLE;
         end
         default: begin
            state_in = uti_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= uti_pkg::ST_IDLE;
         start_time_ff <= '0;
         step_recip_ff <= 32'd65536;
         scale_ff      <= 32'd65536;
         hold_ff       <= 1'b0;
         prepend_ff    <= 1'b0;
         count_ff      <= '0;
         peak_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_time_ff <= start_time_in;
         step_recip_ff <= step_recip_in;
         scale_ff      <= scale_in;
         hold_ff       <= hold_in;
         prepend_ff    <= prepend_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      diff_ff         <= diff_in;
      frac_ff         <= frac_in;
      idx_ff          <= idx_in;
      a_ff            <= a_in;
      unscaled_ff     <= unscaled_in;
      scaled_ff       <= scaled_in;
      rsp_scaled_ff   <= rsp_scaled_in;
      rsp_unscaled_ff <= rsp_unscaled_in;
      rsp_peak_ff     <= rsp_peak_in;
      rsp_status_ff   <= rsp_status_in;
   end

   `UTI_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == uti_pkg::ST_DONE, rsp_strobe_ff, "final step not followed by a result strobe")
   `UTI_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == uti_pkg::ST_IDLE, "result strobe while the sequencer is still busy")
   `UTI_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_DEPTH, "sample count beyond store depth")
   `UTI_ASSERT_NEXT(a_query_starts, clock, reset, start && !busy && req_op == uti_pkg::OP_QUERY, busy, "accepted query did not start the sequencer")
   `UTI_ASSERT_NOW(a_lerp_status, clock, reset, state_ff == uti_pkg::ST_RDB, status_ff == uti_pkg::STATUS_INTERP, "second sample read outside interpolation")

endmodule
